FILE: hw/rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants for the bitmap slot allocator: port widths,
// operation and register codes, register reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package bsa_pkg;

  // Fixed field widths on the ports
  localparam int unsigned OP_W      = 1;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned OFFSET_W  = 26;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 1'b1;

  // Register reset values
  localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 11'd1024;
  localparam logic [SIZE_W-1:0]  SLOT_BYTES_RST = 16'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_MUL,
    ST_DONE
  } state_t;

endpackage

FILE: hw/rtl/bitmap_slot_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Next-fit slot allocator over a bitmap memory, one word checked per cycle.
// ----------------------------------------------------------------------------
// Allocate: scan the bitmap memory read port word by word, from the word of the
//   last hit, then multiply the slot by the slot size for the byte offset.
// Free: read, modify, write of one word; an out-of-range slot skips the word update.
// One item at a time; a new item is taken while the last result waits.
// Reset: a clearing pass writes zero to every bitmap word; no item is
//   accepted meanwhile. WORD_BITS must be a power of two.
module bitmap_slot_allocator #(
  parameter int unsigned MAX_SLOTS = 1024,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsa_pkg::CFG_DAT_W-1:0]   cfg_data,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bsa_pkg::OP_W-1:0]        op,
  input  logic [bsa_pkg::SLOT_W-1:0]      slot,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            status_ok,
  output logic [bsa_pkg::SLOT_W-1:0]      alloc_slot,
  output logic [bsa_pkg::OFFSET_W-1:0]    byte_offset
);

  localparam int unsigned NWORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WA     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned BA     = $clog2(WORD_BITS);
  localparam int unsigned IW     = $clog2(MAX_SLOTS);
  localparam int unsigned CW     = (IW + 1 > bsa_pkg::COUNT_W) ? IW + 1 : bsa_pkg::COUNT_W;
  localparam int unsigned PW     = bsa_pkg::SIZE_W + IW;

  // Configuration registers
  logic [bsa_pkg::COUNT_W-1:0] slot_count;
  logic [bsa_pkg::SIZE_W-1:0]  slot_bytes;

  // Sequencer and datapath registers
  bsa_pkg::state_t             state, state_next;
  logic [WA-1:0]               clr_addr;
  logic [WA-1:0]               search_word;
  logic [WA-1:0]               issue_w;
  logic [WA-1:0]               chk_w;
  logic [WA-1:0]               chk_n;
  logic                        chk_valid;
  logic [WA-1:0]               last_w;
  logic [WORD_BITS-1:0]        last_mask;
  logic [WA-1:0]               free_w;
  logic [BA-1:0]               free_b;
  logic                        res_ok;
  logic [IW-1:0]               res_slot;
  logic [bsa_pkg::OFFSET_W-1:0] res_offset;

  // Bitmap memory
  logic [WORD_BITS-1:0]        mem [NWORDS];
  logic [WORD_BITS-1:0]        rd_data;
  logic                        mem_we;
  logic [WA-1:0]               mem_waddr;
  logic [WORD_BITS-1:0]        mem_wdata;
  logic [WA-1:0]               mem_raddr;

  // Derived from configuration
  logic [CW-1:0]               cnt;
  logic [CW-1:0]               cnt_m1;
  logic [WA-1:0]               last_cur;
  logic [BA-1:0]               rem_cur;
  logic [WORD_BITS-1:0]        mask_cur;
  logic                        free_in_range;

  // Scan datapath
  logic [WORD_BITS-1:0]        avail;
  logic [WORD_BITS-1:0]        low_bit;
  logic [BA-1:0]               bit_idx;
  logic                        found;
  logic [WA-1:0]               issue_w_inc;
  logic [PW-1:0]               product;
  logic                        in_beat;
  logic                        out_free;

  assign cfg_ready = 1'b1;
  assign in_beat   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= bsa_pkg::SLOT_COUNT_RST;
      slot_bytes <= bsa_pkg::SLOT_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bsa_pkg::CFG_SLOT_COUNT: slot_count <= bsa_pkg::COUNT_W'(cfg_data);
        bsa_pkg::CFG_SLOT_BYTES: slot_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the count and derive the last word and its mask
  always_comb begin
    cnt = CW'(slot_count);
    if (cnt == '0) begin
      cnt = CW'(1);
    end
    if (cnt > CW'(MAX_SLOTS)) begin
      cnt = CW'(MAX_SLOTS);
    end
    cnt_m1   = cnt - CW'(1);
    last_cur = WA'(cnt_m1 >> BA);
    rem_cur  = cnt[BA-1:0];
    if (rem_cur == '0) begin
      mask_cur = '1;
    end else begin
      mask_cur = (WORD_BITS'(1) << rem_cur) - WORD_BITS'(1);
    end
    free_in_range = CW'(slot) < cnt;
  end

  // Check the word read last cycle and pick its lowest free bit
  always_comb begin
    avail   = ((chk_w == last_w) ? last_mask : '1) & ~rd_data;
    low_bit = avail & (~avail + WORD_BITS'(1));
    found   = chk_valid && (avail != '0);
    bit_idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (low_bit[j]) begin
        bit_idx = bit_idx | BA'(j);
      end
    end
    issue_w_inc = (issue_w == last_w) ? '0 : issue_w + WA'(1);
    product     = PW'(slot_bytes) * PW'(res_slot);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bsa_pkg::ST_CLEAR: begin
        if (clr_addr == WA'(NWORDS - 1)) begin
          state_next = bsa_pkg::ST_IDLE;
        end
      end
      bsa_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (op == bsa_pkg::OP_ALLOC) begin
            state_next = bsa_pkg::ST_SCAN;
          end else if (free_in_range) begin
            state_next = bsa_pkg::ST_FREE_RD;
          end else begin
            state_next = bsa_pkg::ST_MUL;
          end
        end
      end
      bsa_pkg::ST_SCAN: begin
        if (found || (chk_valid && chk_n == last_w)) begin
          state_next = bsa_pkg::ST_MUL;
        end
      end
      bsa_pkg::ST_FREE_RD: state_next = bsa_pkg::ST_FREE_WR;
      bsa_pkg::ST_FREE_WR: state_next = bsa_pkg::ST_MUL;
      bsa_pkg::ST_MUL:     state_next = bsa_pkg::ST_DONE;
      bsa_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = bsa_pkg::ST_IDLE;
        end
      end
      default: state_next = bsa_pkg::ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer: handshake and memory port control
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = chk_w;
    mem_wdata = rd_data | low_bit;
    mem_raddr = issue_w;
    case (state)
      bsa_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      bsa_pkg::ST_IDLE: in_ready = 1'b1;
      bsa_pkg::ST_SCAN: mem_we = found;
      bsa_pkg::ST_FREE_RD: mem_raddr = free_w;
      bsa_pkg::ST_FREE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = free_w;
        mem_wdata = rd_data & ~(WORD_BITS'(1) << free_b);
      end
      default: ;
    endcase
  end

  // Bitmap memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bsa_pkg::ST_CLEAR;
      clr_addr    <= '0;
      search_word <= '0;
      chk_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bsa_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + WA'(1);
      end
      if (in_beat) begin
        chk_valid <= 1'b0;
      end else if (state == bsa_pkg::ST_SCAN) begin
        chk_valid <= 1'b1;
      end
      if (found && state == bsa_pkg::ST_SCAN) begin
        search_word <= chk_w;
      end
      // Drop the result once taken, load a new one when the register is free
      if (state == bsa_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      last_w    <= last_cur;
      last_mask <= mask_cur;
      issue_w   <= (search_word > last_cur) ? '0 : search_word;
      chk_n     <= '0;
      free_w    <= WA'(slot >> BA);
      free_b    <= slot[BA-1:0];
      res_ok    <= 1'b0;
      res_slot  <= '0;
    end
    case (state)
      bsa_pkg::ST_SCAN: begin
        chk_w   <= issue_w;
        issue_w <= issue_w_inc;
        if (found) begin
          res_ok   <= 1'b1;
          res_slot <= IW'({chk_w, bit_idx});
        end else if (chk_valid) begin
          chk_n <= chk_n + WA'(1);
        end
      end
      bsa_pkg::ST_FREE_WR: res_ok <= 1'b1;
      bsa_pkg::ST_MUL:     res_offset <= bsa_pkg::OFFSET_W'(product);
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == bsa_pkg::ST_DONE && out_free) begin
      status_ok   <= res_ok;
      alloc_slot  <= bsa_pkg::SLOT_W'(res_slot);
      byte_offset <= res_offset;
    end
  end

endmodule
